>>> hw/rtl/rpe_pkg.sv
// shared types and constants of the refinable partition engine
`default_nettype none
package rpe_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_MARK  = 2'd0;
   localparam logic [1:0] OP_SPLIT = 2'd1;
   localparam logic [1:0] OP_QELEM = 2'd2;
   localparam logic [1:0] OP_QSET  = 2'd3;

   // datapath commands, one per sequencer step
   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_FETCH,
      CMD_CHECK,
      CMD_MARK_A,
      CMD_MARK_B,
      CMD_MARK_C,
      CMD_SPLIT_B,
      CMD_RELABEL,
      CMD_FINISH
   } cmd_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic       cfg_wr;
      logic [1:0] op;
      logic       bad;
      logic       mark_go;
      logic       split_go;
      logic       relabel_last;
      logic       clear_last;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

>>> hw/rtl/rpe_ctrl.sv
// sequencer of the refinable partition engine
`default_nettype none
module rpe_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rpe_pkg::status_type status,
   output rpe_pkg::cmd_type        cmd
);
   import rpe_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_FETCH   = 10'b0000000100,
      S_CHECK   = 10'b0000001000,
      S_MARK_A  = 10'b0000010000,
      S_MARK_B  = 10'b0000100000,
      S_MARK_C  = 10'b0001000000,
      S_SPLIT_B = 10'b0010000000,
      S_RELABEL = 10'b0100000000,
      S_FINISH  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NOP;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd      = CMD_LOAD;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd      = CMD_FETCH;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd = CMD_CHECK;
            priority if (status.bad) state_in = S_FINISH;
            else if (status.op == OP_MARK) state_in = S_MARK_A;
            else if (status.op == OP_SPLIT && status.split_go) state_in = S_SPLIT_B;
            else state_in = S_FINISH;
         end
         S_MARK_A: begin
            cmd      = CMD_MARK_A;
            state_in = status.mark_go ? S_MARK_B : S_FINISH;
         end
         S_MARK_B: begin
            cmd      = CMD_MARK_B;
            state_in = S_MARK_C;
         end
         S_MARK_C: begin
            cmd      = CMD_MARK_C;
            state_in = S_FINISH;
         end
         S_SPLIT_B: begin
            cmd      = CMD_SPLIT_B;
            state_in = S_RELABEL;
         end
         S_RELABEL: begin
            cmd = CMD_RELABEL;
            if (status.relabel_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd = CMD_FINISH;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
      if (status.cfg_wr) state_in = S_CLEAR;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      status.cfg_wr |=> state_ff == S_CLEAR)
      else $error("register write did not restart the clearing pass");
   a_relabel_from: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RELABEL |-> $past(state_ff) == S_SPLIT_B || $past(state_ff) == S_RELABEL)
      else $error("relabel entered from wrong step");

endmodule
`default_nettype wire

>>> hw/rtl/rpe_dp.sv
// tables, registers and result word of the refinable partition engine
`default_nettype none
module rpe_dp #(
   parameter int LIM = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rpe_pkg::cmd_type   cmd,
   output rpe_pkg::status_type     status,
   input  wire logic               csr_valid,
   input  wire logic [8:0]         csr_element_count,
   input  wire logic [1:0]         req_operation,
   input  wire logic [7:0]         req_element,
   input  wire logic [7:0]         req_set_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_bad_index,
   output logic [7:0]              rsp_owner_set,
   output logic [7:0]              rsp_next_element,
   output logic                    rsp_next_valid,
   output logic [8:0]              rsp_set_size,
   output logic [7:0]              rsp_first_element,
   output logic                    rsp_has_marks,
   output logic [8:0]              rsp_split_size,
   output logic [8:0]              rsp_set_total
);
   import rpe_pkg::*;

   localparam int IW = $clog2(LIM);
   localparam int NW = IW + 1;

   // memories
   logic [IW-1:0] order_mem [LIM];
   logic [IW-1:0] pos_mem   [LIM];
   logic [IW-1:0] own_mem   [LIM];
   logic [NW-1:0] start_mem [LIM];
   logic [NW-1:0] mid_mem   [LIM];
   logic [NW-1:0] stop_mem  [LIM];

   logic          order_we, pos_we, own_we, start_we, mid_we, stop_we;
   logic          order_re, pos_re, own_re, set_re;
   logic [IW-1:0] order_wa, pos_wa, own_wa, start_wa, mid_wa, stop_wa;
   logic [IW-1:0] order_wd, pos_wd, own_wd;
   logic [NW-1:0] start_wd, mid_wd, stop_wd;
   logic [IW-1:0] order_ra, elem_ra, set_ra;

   logic [IW-1:0] order_rd_ff, pos_rd_ff, own_rd_ff;
   logic [NW-1:0] start_rd_ff, mid_rd_ff, stop_rd_ff;

   // item and control registers
   logic [1:0]    op_ff;
   logic [7:0]    e_ff, s_ff;
   logic          bad_ff, bad_in;
   logic [NW-1:0] split_size_ff;
   logic [NW-1:0] ptr_ff;
   logic [IW-1:0] clr_ff;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] cnt_ff;
   logic          rsp_valid_ff;

   logic [IW-1:0] e_idx, s_idx;
   logic [NW-1:0] nxt;
   logic          mark_go, split_go, relabel_last, clear_last, out_free, elem_op;
   logic          nxt_ok;
   logic [8:0]    clamp_v;

   assign e_idx        = e_ff[IW-1:0];
   assign s_idx        = s_ff[IW-1:0];
   assign nxt          = NW'(pos_rd_ff) + NW'(1);
   assign nxt_ok       = (nxt < stop_rd_ff) && (nxt < NW'(LIM));
   assign elem_op      = (op_ff == OP_MARK) || (op_ff == OP_QELEM);
   assign mark_go      = mid_rd_ff <= NW'(pos_rd_ff);
   assign split_go     = (mid_rd_ff != stop_rd_ff) && (mid_rd_ff != start_rd_ff)
                         && (cnt_ff < NW'(LIM));
   assign relabel_last = ptr_ff >= mid_rd_ff;
   assign clear_last   = clr_ff == IW'(LIM - 1);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // range check of the pending item
   always_comb begin
      if (elem_op) bad_in = {1'b0, e_ff} >= 9'(n_ff);
      else bad_in = {1'b0, s_ff} >= 9'(cnt_ff);
   end

   // clamp of a written element count
   always_comb begin
      clamp_v = csr_element_count;
      if (clamp_v == 9'd0) clamp_v = 9'd1;
      if (32'(clamp_v) > LIM) clamp_v = 9'(LIM);
      n_in = NW'(clamp_v);
   end

   assign status = '{cfg_wr: csr_valid, op: op_ff, bad: bad_in, mark_go: mark_go,
                     split_go: split_go, relabel_last: relabel_last,
                     clear_last: clear_last, out_free: out_free};

   // memory port control per step
   always_comb begin
      order_we = 1'b0; pos_we = 1'b0; own_we = 1'b0;
      start_we = 1'b0; mid_we = 1'b0; stop_we = 1'b0;
      order_re = 1'b0; pos_re = 1'b0; own_re = 1'b0; set_re = 1'b0;
      order_wa = '0; pos_wa = '0; own_wa = '0; start_wa = '0; mid_wa = '0; stop_wa = '0;
      order_wd = '0; pos_wd = '0; own_wd = '0; start_wd = '0; mid_wd = '0; stop_wd = '0;
      order_ra = '0; elem_ra = '0; set_ra = '0;
      unique case (cmd)
         CMD_CLEAR: begin
            order_we = 1'b1; pos_we = 1'b1; own_we = 1'b1;
            start_we = 1'b1; mid_we = 1'b1; stop_we = 1'b1;
            order_wa = clr_ff; pos_wa = clr_ff; own_wa = clr_ff;
            start_wa = clr_ff; mid_wa = clr_ff; stop_wa = clr_ff;
            order_wd = clr_ff; pos_wd = clr_ff;
            stop_wd  = (clr_ff == '0) ? n_ff : '0;
         end
         CMD_FETCH: begin
            own_re = 1'b1; pos_re = 1'b1; elem_ra = e_idx;
            set_re = 1'b1; set_ra = s_idx;
         end
         CMD_CHECK: begin
            if (elem_op) begin
               set_re   = 1'b1; set_ra = own_rd_ff;
               order_re = 1'b1; order_ra = nxt[IW-1:0];
            end else if (op_ff == OP_QSET) begin
               order_re = 1'b1; order_ra = start_rd_ff[IW-1:0];
            end else if (!bad_in) begin
               if (split_go) begin
                  start_we = 1'b1; start_wa = cnt_ff[IW-1:0]; start_wd = start_rd_ff;
                  mid_we   = 1'b1; mid_wa   = cnt_ff[IW-1:0]; mid_wd   = start_rd_ff;
                  stop_we  = 1'b1; stop_wa  = cnt_ff[IW-1:0]; stop_wd  = mid_rd_ff;
               end else if (mid_rd_ff == stop_rd_ff) begin
                  // all elements marked: clear the marks
                  mid_we = 1'b1; mid_wa = s_idx; mid_wd = start_rd_ff;
               end
            end
         end
         CMD_MARK_A: begin
            order_re = mark_go; order_ra = mid_rd_ff[IW-1:0];
         end
         CMD_MARK_B: begin
            order_we = 1'b1; order_wa = pos_rd_ff; order_wd = order_rd_ff;
            pos_we   = 1'b1; pos_wa   = order_rd_ff; pos_wd = pos_rd_ff;
         end
         CMD_MARK_C: begin
            order_we = 1'b1; order_wa = mid_rd_ff[IW-1:0]; order_wd = e_idx;
            pos_we   = 1'b1; pos_wa   = e_idx; pos_wd = mid_rd_ff[IW-1:0];
            mid_we   = 1'b1; mid_wa   = own_rd_ff; mid_wd = mid_rd_ff + NW'(1);
         end
         CMD_SPLIT_B: begin
            start_we = 1'b1; start_wa = s_idx; start_wd = mid_rd_ff;
            order_re = 1'b1; order_ra = start_rd_ff[IW-1:0];
         end
         CMD_RELABEL: begin
            own_we   = 1'b1; own_wa = order_rd_ff; own_wd = cnt_ff[IW-1:0];
            order_re = !relabel_last; order_ra = ptr_ff[IW-1:0];
         end
         default: ;
      endcase
   end

   // element tables
   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      if (order_re) order_rd_ff <= order_mem[order_ra];
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      if (pos_re) pos_rd_ff <= pos_mem[elem_ra];
      if (own_we) own_mem[own_wa] <= own_wd;
      if (own_re) own_rd_ff <= own_mem[elem_ra];
   end

   // set tables
   always_ff @(posedge clock) begin
      if (start_we) start_mem[start_wa] <= start_wd;
      if (mid_we) mid_mem[mid_wa] <= mid_wd;
      if (stop_we) stop_mem[stop_wa] <= stop_wd;
      if (set_re) begin
         start_rd_ff <= start_mem[set_ra];
         mid_rd_ff   <= mid_mem[set_ra];
         stop_rd_ff  <= stop_mem[set_ra];
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         op_ff         <= req_operation;
         e_ff          <= req_element;
         s_ff          <= req_set_id;
         split_size_ff <= '0;
      end
      if (cmd == CMD_CHECK) bad_ff <= bad_in;
      if (cmd == CMD_SPLIT_B) begin
         split_size_ff <= mid_rd_ff - start_rd_ff;
         ptr_ff        <= start_rd_ff + NW'(1);
      end else if (cmd == CMD_RELABEL && !relabel_last) begin
         ptr_ff <= ptr_ff + NW'(1);
      end
   end

   // element count, set count and clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= NW'(LIM);
         cnt_ff <= NW'(1);
         clr_ff <= '0;
      end else if (csr_valid) begin
         n_ff   <= n_in;
         cnt_ff <= NW'(1);
         clr_ff <= '0;
      end else begin
         if (cmd == CMD_CLEAR) clr_ff <= clear_last ? '0 : clr_ff + IW'(1);
         if (cmd == CMD_RELABEL && relabel_last) cnt_ff <= cnt_ff + NW'(1);
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == CMD_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_FINISH && out_free) begin
         rsp_bad_index     <= bad_ff;
         rsp_owner_set     <= '0;
         rsp_next_element  <= '0;
         rsp_next_valid    <= 1'b0;
         rsp_set_size      <= '0;
         rsp_first_element <= '0;
         rsp_has_marks     <= 1'b0;
         rsp_split_size    <= '0;
         rsp_set_total     <= 9'(cnt_ff);
         if (!bad_ff) begin
            unique case (op_ff)
               OP_QELEM: begin
                  rsp_owner_set <= 8'(own_rd_ff);
                  if (nxt_ok) begin
                     rsp_next_element <= 8'(order_rd_ff);
                     rsp_next_valid   <= 1'b1;
                  end
               end
               OP_QSET: begin
                  rsp_set_size <= 9'(stop_rd_ff - start_rd_ff);
                  if (start_rd_ff < NW'(LIM)) rsp_first_element <= 8'(order_rd_ff);
                  rsp_has_marks <= mid_rd_ff != start_rd_ff;
               end
               OP_SPLIT: rsp_split_size <= 9'(split_size_ff);
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= n_ff)
      else $error("set count above element count");
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished item not presented");
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_RELABEL |-> ptr_ff <= mid_rd_ff)
      else $error("relabel pointer past marked run");

endmodule
`default_nettype wire

>>> hw/rtl/refinable_partition_engine_unit.sv
// top level of the refinable partition engine
//
// channel  direction  handshake        payload
// req      in         valid / stall    operation, element, set_id
// rsp      out        valid / stall    bad_index .. set_total
// csr      in         valid / ready    element_count
//
// steps per accepted word: a query, an out-of-range index or a split that moves
// nothing runs fetch, check, finish; mark runs fetch, check, mark_a/b/c, finish,
// with mark_a going to finish if the element is already marked; split runs fetch,
// check, split_b, relabel (each element via the owner table's one port), finish.
// after reset and after every element_count write a clearing pass over
// min(MAX_ELEMENTS,256) entries initializes the tables; req stays stalled meanwhile.
// a finished word waits in the rsp register; the next word is accepted meanwhile.
`default_nettype none
module refinable_partition_engine_unit #(
   parameter int MAX_ELEMENTS = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_element,
   input  wire logic [7:0] req_set_id,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_bad_index,
   output logic [7:0]      rsp_owner_set,
   output logic [7:0]      rsp_next_element,
   output logic            rsp_next_valid,
   output logic [8:0]      rsp_set_size,
   output logic [7:0]      rsp_first_element,
   output logic            rsp_has_marks,
   output logic [8:0]      rsp_split_size,
   output logic [8:0]      rsp_set_total,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [8:0] csr_element_count
);
   import rpe_pkg::*;

   localparam int LIM = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   rpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpe_dp #(.LIM(LIM)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_element_count (csr_element_count),
      .req_operation     (req_operation),
      .req_element       (req_element),
      .req_set_id        (req_set_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bad_index     (rsp_bad_index),
      .rsp_owner_set     (rsp_owner_set),
      .rsp_next_element  (rsp_next_element),
      .rsp_next_valid    (rsp_next_valid),
      .rsp_set_size      (rsp_set_size),
      .rsp_first_element (rsp_first_element),
      .rsp_has_marks     (rsp_has_marks),
      .rsp_split_size    (rsp_split_size),
      .rsp_set_total     (rsp_set_total)
   );

endmodule
`default_nettype wire
